[rtl/core/ltis_pkg.sv]
// ----------------------------------------------------------------------------
// Locality tier instance selector package
// Shared constants, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ltis_pkg;

    localparam int MAX_INSTANCES_DEF = 64;
    localparam int PCT_SCALE         = 100;
    localparam int ID_W              = 16;
    localparam int PCT_W             = 7;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int ENTRY_W           = ID_W + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGRADE_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNHEALTHY_PCT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_REGION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_ZONE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_CAMPUS = 3'd7;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_FALL,
        CMD_DECIDE,
        CMD_WIDEN,
        CMD_PLAIN,
        CMD_READ,
        CMD_CHECK,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic total_zero;
        logic degrade_hit;
        logic ml_is_low;
        logic widen_ok;
        logic wlv_is_low;
        logic plain_scan;
        logic chk_stall;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

[rtl/core/locality_tier_instance_selector.sv]
// ----------------------------------------------------------------------------
// Locality tier instance selector
// Loads a set of instances, picks a locality tier and emits the chosen ids.
// ----------------------------------------------------------------------------
// Instances are loaded at one transfer per cycle. The transfer marked set_last
// starts a selection: a tier decision (one widening step per cycle), then,
// unless the chosen tier is empty or holds nothing to emit, a scan of the
// single-port instance store that reads and then checks each stored entry for
// every tier emitted (one to four tiers), then the closing result. No new item
// is taken during a selection. Results leave through an output register, so
// the scan pauses only while that register is full and not taken.
module locality_tier_instance_selector import ltis_pkg::*; #(
    parameter int MAX_INSTANCES = MAX_INSTANCES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ID_W-1:0]       s_instance_id,
    input  logic                  s_instance_present,
    input  logic [ID_W-1:0]       s_region_id,
    input  logic [ID_W-1:0]       s_zone_id,
    input  logic [ID_W-1:0]       s_campus_id,
    input  logic                  s_healthy,
    input  logic                  s_nearby_enable,
    input  logic                  s_set_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ID_W-1:0]       m_selected_id,
    output logic                  m_has_instance,
    output logic [1:0]            m_chosen_level,
    output logic                  m_recovered,
    output logic                  m_overflow,
    output logic                  m_run_last
);

    cmd_t cmd;
    sts_t sts;

    ltis_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_set_last (s_set_last),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ltis_dp #(
        .MAX_INSTANCES (MAX_INSTANCES)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_idx            (cfg_idx),
        .cfg_data           (cfg_data),
        .cmd                (cmd),
        .sts                (sts),
        .s_instance_id      (s_instance_id),
        .s_instance_present (s_instance_present),
        .s_region_id        (s_region_id),
        .s_zone_id          (s_zone_id),
        .s_campus_id        (s_campus_id),
        .s_healthy          (s_healthy),
        .s_nearby_enable    (s_nearby_enable),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_selected_id      (m_selected_id),
        .m_has_instance     (m_has_instance),
        .m_chosen_level     (m_chosen_level),
        .m_recovered        (m_recovered),
        .m_overflow         (m_overflow),
        .m_run_last         (m_run_last)
    );

endmodule

[rtl/core/ltis_ctrl.sv]
// ----------------------------------------------------------------------------
// Locality tier selector controller
// Sequences loading, tier decision, store scan and the closing result.
// ----------------------------------------------------------------------------
module ltis_ctrl import ltis_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_set_last,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FALL,
        ST_DECIDE,
        ST_WIDEN,
        ST_PLAIN,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_IDLE;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_ready_reg) begin
                    cmd = CMD_LOAD;
                    if (s_set_last) begin
                        state_next = ST_FALL;
                    end
                end
            end
            ST_FALL: begin
                cmd        = CMD_FALL;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd = CMD_DECIDE;
                if (sts.total_zero) begin
                    state_next = ST_FINISH;
                end else if (sts.degrade_hit && !sts.ml_is_low) begin
                    state_next = ST_WIDEN;
                end else begin
                    state_next = ST_PLAIN;
                end
            end
            ST_WIDEN: begin
                cmd = CMD_WIDEN;
                if (sts.widen_ok) begin
                    state_next = ST_READ;
                end else if (sts.wlv_is_low) begin
                    state_next = ST_PLAIN;
                end
            end
            ST_PLAIN: begin
                cmd        = CMD_PLAIN;
                state_next = sts.plain_scan ? ST_READ : ST_FINISH;
            end
            ST_READ: begin
                cmd        = CMD_READ;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sts.chk_stall) begin
                    cmd        = CMD_CHECK;
                    state_next = sts.scan_done ? ST_FINISH : ST_READ;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd        = CMD_FINISH;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_LOAD);
        end
    end

endmodule

[rtl/core/ltis_dp.sv]
// ----------------------------------------------------------------------------
// Locality tier selector datapath
// Configuration, instance store, tier counters, decision arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module ltis_dp import ltis_pkg::*; #(
    parameter int MAX_INSTANCES = MAX_INSTANCES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [ID_W-1:0]       s_instance_id,
    input  logic                  s_instance_present,
    input  logic [ID_W-1:0]       s_region_id,
    input  logic [ID_W-1:0]       s_zone_id,
    input  logic [ID_W-1:0]       s_campus_id,
    input  logic                  s_healthy,
    input  logic                  s_nearby_enable,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ID_W-1:0]       m_selected_id,
    output logic                  m_has_instance,
    output logic [1:0]            m_chosen_level,
    output logic                  m_recovered,
    output logic                  m_overflow,
    output logic                  m_run_last
);

    localparam int AW = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int CW = $clog2(MAX_INSTANCES + 1);
    localparam int PW = CW + PCT_W;

    // Configuration registers.
    logic [1:0]       match_level_reg, max_match_reg;
    logic             degrade_en_reg, recover_en_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [ID_W-1:0]  client_region_reg, client_zone_reg, client_campus_reg;

    // Set state.
    logic [ENTRY_W-1:0] store_mem [MAX_INSTANCES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      tot_reg [4];
    logic [CW-1:0]      unh_reg [4];
    logic               ovf_reg;

    // Selection state.
    logic [1:0]    sel_ml_reg, wlv_reg, cur_tier_reg, end_tier_reg;
    logic          sel_rec_reg, want_h_reg;
    logic [CW-1:0] acc_t_reg, acc_u_reg;
    logic [AW-1:0] idx_reg;
    logic          pend_valid_reg;
    logic [ID_W-1:0] pend_id_reg;

    // Output register.
    logic            m_valid_reg, m_has_reg, m_rec_reg, m_ovf_reg, m_last_reg;
    logic [ID_W-1:0] m_id_reg;
    logic [1:0]      m_lvl_reg;

    logic [1:0]    load_tier, low_lvl, ml_fb;
    logic [CW-1:0] sum_t, sum_u;
    logic [PW-1:0] dec_u_prod, dec_t_prod, wid_u_prod, wid_t_prod;
    logic          out_free, match, idx_last, healthy_avail, push_chk;

    assign low_lvl = (max_match_reg < match_level_reg) ? max_match_reg : match_level_reg;

    always_comb begin
        load_tier = 2'd0;
        if (!s_nearby_enable) begin
            load_tier = match_level_reg;
        end else if (match_level_reg >= 2'd1 && s_region_id == client_region_reg) begin
            load_tier = 2'd1;
            if (match_level_reg >= 2'd2 && s_zone_id == client_zone_reg) begin
                load_tier = 2'd2;
                if (match_level_reg == 2'd3 && s_campus_id == client_campus_reg) begin
                    load_tier = 2'd3;
                end
            end
        end
    end

    // Fall back from the match level past empty tiers, no lower than low_lvl.
    always_comb begin
        ml_fb = match_level_reg;
        for (int k = 0; k < 3; k++) begin
            if (tot_reg[ml_fb] == '0 && ml_fb > low_lvl) begin
                ml_fb = ml_fb - 2'd1;
            end
        end
    end

    assign dec_u_prod = PW'(acc_u_reg) * PW'(PCT_SCALE);
    assign dec_t_prod = PW'(acc_t_reg) * PW'(pct_reg);
    assign sum_t      = acc_t_reg + tot_reg[wlv_reg];
    assign sum_u      = acc_u_reg + unh_reg[wlv_reg];
    assign wid_u_prod = PW'(sum_u) * PW'(PCT_SCALE);
    assign wid_t_prod = PW'(sum_t) * PW'(pct_reg);

    assign healthy_avail = tot_reg[sel_ml_reg] > unh_reg[sel_ml_reg];
    assign out_free      = !m_valid_reg || m_ready;
    assign match         = (rd_data_reg[ID_W +: 2] == cur_tier_reg)
                           && (rd_data_reg[ENTRY_W-1] == want_h_reg);
    assign idx_last      = (CW'(idx_reg) == count_reg - CW'(1));
    assign push_chk      = (cmd == CMD_CHECK) && match && pend_valid_reg;

    always_comb begin
        sts.total_zero  = (acc_t_reg == '0);
        sts.degrade_hit = degrade_en_reg && (dec_u_prod >= dec_t_prod);
        sts.ml_is_low   = (sel_ml_reg == low_lvl);
        sts.widen_ok    = (wid_u_prod < wid_t_prod);
        sts.wlv_is_low  = (wlv_reg == low_lvl);
        sts.plain_scan  = healthy_avail || recover_en_reg;
        sts.chk_stall   = match && pend_valid_reg && !out_free;
        sts.scan_done   = idx_last && (cur_tier_reg == end_tier_reg);
        sts.out_free    = out_free;
    end

    // Store writes and reads.
    always_ff @(posedge aclk) begin
        if (cmd == CMD_LOAD && s_instance_present && count_reg < CW'(MAX_INSTANCES)) begin
            store_mem[count_reg[AW-1:0]] <= {s_healthy, load_tier, s_instance_id};
        end
        if (cmd == CMD_READ) begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    // Payload registers of the selection.
    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_FALL: begin
                sel_ml_reg  <= ml_fb;
                acc_t_reg   <= tot_reg[ml_fb];
                acc_u_reg   <= unh_reg[ml_fb];
                sel_rec_reg <= 1'b0;
            end
            CMD_DECIDE: begin
                wlv_reg <= sel_ml_reg - 2'd1;
            end
            CMD_WIDEN: begin
                acc_t_reg <= sum_t;
                acc_u_reg <= sum_u;
                wlv_reg   <= wlv_reg - 2'd1;
                if (wid_u_prod < wid_t_prod) begin
                    cur_tier_reg <= sel_ml_reg;
                    end_tier_reg <= wlv_reg;
                    want_h_reg   <= 1'b1;
                    sel_rec_reg  <= 1'b1;
                    idx_reg      <= '0;
                end
            end
            CMD_PLAIN: begin
                cur_tier_reg <= sel_ml_reg;
                end_tier_reg <= sel_ml_reg;
                idx_reg      <= '0;
                want_h_reg   <= healthy_avail;
                sel_rec_reg  <= healthy_avail ? (sel_ml_reg != match_level_reg)
                              : (recover_en_reg || (sel_ml_reg != match_level_reg));
            end
            CMD_CHECK: begin
                if (match) begin
                    pend_id_reg <= rd_data_reg[ID_W-1:0];
                end
                if (idx_last) begin
                    idx_reg      <= '0;
                    cur_tier_reg <= cur_tier_reg - 2'd1;
                end else begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            default: ;
        endcase
        if (push_chk || cmd == CMD_FINISH) begin
            m_id_reg  <= (cmd == CMD_FINISH && !pend_valid_reg) ? '0 : pend_id_reg;
            m_has_reg <= pend_valid_reg;
            m_lvl_reg <= sel_ml_reg;
            m_rec_reg <= sel_rec_reg;
            m_ovf_reg <= ovf_reg;
            m_last_reg <= (cmd == CMD_FINISH);
        end
    end

    // Control state: configuration, counters and valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_level_reg   <= 2'd2;
            max_match_reg     <= 2'd0;
            degrade_en_reg    <= 1'b1;
            pct_reg           <= PCT_W'(PCT_SCALE);
            recover_en_reg    <= 1'b1;
            client_region_reg <= '0;
            client_zone_reg   <= '0;
            client_campus_reg <= '0;
            count_reg         <= '0;
            ovf_reg           <= 1'b0;
            pend_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
            for (int t = 0; t < 4; t++) begin
                tot_reg[t] <= '0;
                unh_reg[t] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_MATCH_LEVEL:   match_level_reg   <= cfg_data[1:0];
                    CFG_MAX_MATCH:     max_match_reg     <= cfg_data[1:0];
                    CFG_DEGRADE_EN:    degrade_en_reg    <= cfg_data[0];
                    CFG_UNHEALTHY_PCT: pct_reg           <= cfg_data[PCT_W-1:0];
                    CFG_RECOVER_EN:    recover_en_reg    <= cfg_data[0];
                    CFG_CLIENT_REGION: client_region_reg <= cfg_data;
                    CFG_CLIENT_ZONE:   client_zone_reg   <= cfg_data;
                    CFG_CLIENT_CAMPUS: client_campus_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd == CMD_LOAD && s_instance_present) begin
                if (count_reg < CW'(MAX_INSTANCES)) begin
                    count_reg          <= count_reg + CW'(1);
                    tot_reg[load_tier] <= tot_reg[load_tier] + CW'(1);
                    if (!s_healthy) begin
                        unh_reg[load_tier] <= unh_reg[load_tier] + CW'(1);
                    end
                end else begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd == CMD_CHECK && match) begin
                pend_valid_reg <= 1'b1;
            end

            if (push_chk || cmd == CMD_FINISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // The set is cleared once its closing result is loaded.
            if (cmd == CMD_FINISH) begin
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
                pend_valid_reg <= 1'b0;
                for (int t = 0; t < 4; t++) begin
                    tot_reg[t] <= '0;
                    unh_reg[t] <= '0;
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_selected_id  = m_id_reg;
    assign m_has_instance = m_has_reg;
    assign m_chosen_level = m_lvl_reg;
    assign m_recovered    = m_rec_reg;
    assign m_overflow     = m_ovf_reg;
    assign m_run_last     = m_last_reg;

endmodule

[rtl/core/ltis_chk.sv]
// ----------------------------------------------------------------------------
// Locality tier selector port checker
// Watches the top-level ports over time and flags broken behavior.
// ----------------------------------------------------------------------------
module ltis_chk import ltis_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            s_set_last,
    input logic            m_valid,
    input logic            m_ready,
    input logic [ID_W-1:0] m_selected_id,
    input logic            m_has_instance,
    input logic            m_run_last
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_selected_id) && $stable(m_run_last))
        else $error("result changed while stalled");

    // The closing transfer of a set starts a selection that takes no new item.
    a_sel_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_set_last |=> !s_ready)
        else $error("input taken right after set_last");

    // An empty selection is always the only and last result of its run.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_instance |-> m_run_last && m_selected_id == '0)
        else $error("empty result not last or id not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind locality_tier_instance_selector ltis_chk u_ltis_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_set_last     (s_set_last),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_selected_id  (m_selected_id),
    .m_has_instance (m_has_instance),
    .m_run_last     (m_run_last)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Locality tier instance selector testbench
// Loads instance sets under several register settings and predicts every
// selection run; each result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ltis_pkg::*;

    typedef struct packed {
        logic [15:0] id;
        logic        has;
        logic [1:0]  lvl;
        logic        rec;
        logic        ovf;
        logic        last;
    } pick_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  tier;
        logic        healthy;
    } entry_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_instance_id = '0;
    logic s_instance_present = 1'b0;
    logic [15:0] s_region_id = '0;
    logic [15:0] s_zone_id = '0;
    logic [15:0] s_campus_id = '0;
    logic s_healthy = 1'b0;
    logic s_nearby_enable = 1'b0;
    logic s_set_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_selected_id;
    logic m_has_instance;
    logic [1:0] m_chosen_level;
    logic m_recovered;
    logic m_overflow;
    logic m_run_last;

    locality_tier_instance_selector dut (.*);

    // Predictor state: register copies and the set being loaded.
    logic [1:0] r_match, r_maxm;
    logic r_degrade, r_recover;
    logic [6:0] r_pct;
    logic [15:0] r_region, r_zone, r_campus;
    entry_t set_store[$];
    int tier_cnt[4], tier_bad[4];
    bit set_ovf;
    pick_t expected_picks[$];
    int errors = 0;
    bit quiet = 0;
    longint cycles = 0;

    initial forever #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[locality_tier_instance_selector] ERROR");
            $finish;
        end
    end

    // Result checker and receiver stalls.
    always @(posedge aclk) begin
        pick_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_selected_id, m_has_instance, m_chosen_level, m_recovered,
                    m_overflow, m_run_last};
            if (expected_picks.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
            end else begin
                want = expected_picks.pop_front();
                if (got != want) begin
                    errors++;
                    $display("%0t: expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    initial begin
        int n;
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge aclk);
            if (!quiet && $urandom_range(0, 1)) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
    end

    function automatic void push_pick(logic [15:0] id, logic has, logic [1:0] lvl,
                                      logic rec);
        pick_t p;
        p = '{id, has, lvl, rec, set_ovf, 1'b0};
        expected_picks = {expected_picks, p};
    endfunction

    function automatic int push_tier(int tier, logic want_ok, logic [1:0] lvl,
                                     logic rec);
        int n = 0;
        foreach (set_store[i])
            if (set_store[i].tier == tier && set_store[i].healthy == want_ok) begin
                push_pick(set_store[i].id, 1'b1, lvl, rec);
                n++;
            end
        return n;
    endfunction

    function automatic void predict_selection();
        int top, low, ml, total, bad, deg, emitted;
        logic rec;
        top = r_match;
        low = (r_maxm < top) ? r_maxm : top;
        ml = top;
        total = tier_cnt[ml];
        emitted = 0;
        rec = 0;
        while (total == 0 && ml > low) begin
            ml--;
            total = tier_cnt[ml];
        end
        if (total == 0) begin
            push_pick(16'd0, 1'b0, ml[1:0], 1'b0);
            return;
        end
        bad = tier_bad[ml];
        if (r_degrade && bad * 100 >= total * r_pct) begin
            deg = -1;
            for (int lv = ml - 1; lv >= low; lv--) begin
                total += tier_cnt[lv];
                bad += tier_bad[lv];
                if (bad * 100 < total * r_pct) begin
                    deg = lv;
                    break;
                end
            end
            if (deg >= low) begin
                for (int lv = ml; lv >= deg; lv--)
                    emitted += push_tier(lv, 1'b1, ml[1:0], 1'b1);
                if (emitted == 0) push_pick(16'd0, 1'b0, ml[1:0], 1'b1);
                return;
            end
        end
        if (tier_cnt[ml] > tier_bad[ml]) begin
            rec = (ml != top);
            emitted = push_tier(ml, 1'b1, ml[1:0], rec);
        end else if (r_recover) begin
            rec = 1'b1;
            emitted = push_tier(ml, 1'b0, ml[1:0], rec);
        end else begin
            rec = (ml != top);
        end
        if (emitted == 0) push_pick(16'd0, 1'b0, ml[1:0], rec);
    endfunction

    function automatic void predict_item(logic [15:0] id, logic present,
                                         logic [15:0] rg, logic [15:0] zn,
                                         logic [15:0] cp, logic ok, logic near,
                                         logic last);
        int tier;
        entry_t ent;
        if (present) begin
            tier = 0;
            if (!near) tier = r_match;
            else if (r_match >= 1 && rg == r_region) begin
                tier = 1;
                if (r_match >= 2 && zn == r_zone) begin
                    tier = 2;
                    if (r_match >= 3 && cp == r_campus) tier = 3;
                end
            end
            if (set_store.size() < 64) begin
                ent = '{id, tier[1:0], ok};
                set_store = {set_store, ent};
                tier_cnt[tier]++;
                if (!ok) tier_bad[tier]++;
            end else begin
                set_ovf = 1'b1;
            end
        end
        if (last) begin
            predict_selection();
            expected_picks[expected_picks.size() - 1].last = 1'b1;
            set_store.delete();
            tier_cnt = '{default: 0};
            tier_bad = '{default: 0};
            set_ovf = 1'b0;
        end
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_picks.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        case (idx)
            CFG_MATCH_LEVEL:   r_match = val[1:0];
            CFG_MAX_MATCH:     r_maxm = val[1:0];
            CFG_DEGRADE_EN:    r_degrade = val[0];
            CFG_UNHEALTHY_PCT: r_pct = val[6:0];
            CFG_RECOVER_EN:    r_recover = val[0];
            CFG_CLIENT_REGION: r_region = val;
            CFG_CLIENT_ZONE:   r_zone = val;
            default:           r_campus = val;
        endcase
    endtask

    task automatic set_policy(int ml, int mx, int dg, int pct, int rc);
        wait_drained();
        write_reg(CFG_MATCH_LEVEL, 16'(ml));
        write_reg(CFG_MAX_MATCH, 16'(mx));
        write_reg(CFG_DEGRADE_EN, 16'(dg));
        write_reg(CFG_UNHEALTHY_PCT, 16'(pct));
        write_reg(CFG_RECOVER_EN, 16'(rc));
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so the next item or an idle gap takes over there.
    task automatic send_instance(logic [15:0] id, logic present, logic [15:0] rg,
                                 logic [15:0] zn, logic [15:0] cp, logic ok,
                                 logic near, logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_instance_id <= id;
        s_instance_present <= present;
        s_region_id <= rg;
        s_zone_id <= zn;
        s_campus_id <= cp;
        s_healthy <= ok;
        s_nearby_enable <= near;
        s_set_last <= last;
        do @(posedge aclk); while (!s_ready);
        predict_item(id, present, rg, zn, cp, ok, near, last);
        @(negedge aclk);
    endtask

    // Location drawn near the client so that every tier gets used.
    task automatic send_local(logic ok, logic last);
        logic [15:0] rg, zn, cp;
        rg = $urandom_range(0, 3) ? r_region : 16'($urandom);
        zn = $urandom_range(0, 2) ? r_zone : 16'($urandom);
        cp = $urandom_range(0, 1) ? r_campus : 16'($urandom);
        send_instance(16'($urandom), 1'b1, rg, zn, cp, ok, $urandom_range(0, 5) != 0,
                      last);
    endtask

    task automatic test_directed();
        set_policy(3, 0, 1, 50, 1);
        write_reg(CFG_CLIENT_REGION, 16'hffff);
        write_reg(CFG_CLIENT_ZONE, 16'h0000);
        write_reg(CFG_CLIENT_CAMPUS, 16'h8001);
        // Empty set ended by an item without an instance.
        send_instance(16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
        // Campus match, zone match, region only, no match, nearby off.
        send_instance(16'h0000, 1'b1, 16'hffff, 16'h0000, 16'h8001, 1'b1, 1'b1, 1'b0);
        send_instance(16'hffff, 1'b1, 16'hffff, 16'h0000, 16'h7ffe, 1'b0, 1'b1, 1'b0);
        send_instance(16'h1234, 1'b1, 16'hffff, 16'hffff, 16'h8001, 1'b1, 1'b1, 1'b0);
        send_instance(16'h5678, 1'b1, 16'h0000, 16'h0000, 16'h8001, 1'b0, 1'b1, 1'b0);
        send_instance(16'h9abc, 1'b1, 16'h0000, 16'hffff, 16'hffff, 1'b0, 1'b0, 1'b1);
        // Tier with only unhealthy instances, recover-all then plain empty.
        send_instance(16'h0a0a, 1'b1, 16'hffff, 16'h0000, 16'h8001, 1'b0, 1'b1, 1'b1);
        set_policy(3, 3, 0, 100, 0);
        send_instance(16'h0b0b, 1'b1, 16'hffff, 16'h0000, 16'h8001, 1'b0, 1'b1, 1'b1);
        // Fallback past empty tiers down to the lowest allowed one.
        set_policy(2, 1, 1, 0, 1);
        send_instance(16'h0c0c, 1'b1, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0);
        send_instance(16'h0d0d, 1'b1, 16'hffff, 16'h0001, 16'h0000, 1'b1, 1'b1, 1'b1);
        set_policy(2, 0, 1, 127, 0);
        send_instance(16'h0e0e, 1'b1, 16'hffff, 16'h0001, 16'h0000, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_overflow();
        set_policy(0, 0, 0, 100, 1);
        for (int i = 0; i < 66; i++) send_local(i[0], i == 65);
    endtask

    task automatic test_random_sets(int sets, int policy_mix);
        int len, done;
        done = 0;
        while (done < sets) begin
            if (done % policy_mix == 0) begin
                set_policy($urandom_range(0, 3), $urandom_range(0, 3),
                           $urandom_range(0, 1), $urandom_range(1, 100),
                           $urandom_range(0, 1));
                write_reg(CFG_CLIENT_REGION, 16'($urandom));
                write_reg(CFG_CLIENT_ZONE, 16'($urandom));
                write_reg(CFG_CLIENT_CAMPUS, 16'($urandom));
            end
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                if ($urandom_range(0, 9) == 0)
                    send_instance(16'($urandom), 1'b0, 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'($urandom), 1'($urandom),
                                  i == len - 1);
                else
                    send_local($urandom_range(0, 2) != 0, i == len - 1);
            if (done == 2) wait_drained();
            done++;
        end
    endtask

    initial begin
        r_match = 2; r_maxm = 0; r_degrade = 1; r_pct = 100; r_recover = 1;
        r_region = 0; r_zone = 0; r_campus = 0;
        tier_cnt = '{default: 0};
        tier_bad = '{default: 0};
        set_ovf = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_overflow();
        test_random_sets(4, 2);
        quiet = 1;
        test_random_sets(2, 2);
        wait_drained();
        if (errors == 0 && expected_picks.size() == 0)
            $display("[locality_tier_instance_selector] OK");
        else
            $display("[locality_tier_instance_selector] ERROR");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/ltis_pkg.sv
rtl/core/ltis_ctrl.sv
rtl/core/ltis_dp.sv
rtl/core/locality_tier_instance_selector.sv
rtl/core/ltis_chk.sv
tb/testbench.sv
